// File: rtl/wspd_pkg.sv
// Shared types and constants for the wheel speed PI drive core.
// Holds the microcode ROM, control word layout and configuration record.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package wspd_pkg;

    // fixed datapath widths, sized from the field ranges
    localparam int UPC_W    = 5;
    localparam int CNT_W    = 6;
    localparam int DIV_BITS = 56;
    localparam int ACC_W    = 58;
    localparam int MUL_A_W  = 34;
    localparam int MUL_B_W  = 16;
    localparam int MUL_P_W  = 51;
    localparam int WHEEL_W  = 33;
    localparam int SUM_W    = 41;
    localparam int INTEG_W  = 32;
    localparam int DACC_W   = 33;
    localparam int REQ_W    = 15;
    localparam int ERR_W    = 16;
    localparam int DRIVE_W  = 17;
    localparam int DEN_W    = 14;

    localparam int DEADBAND_RPM = 50;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_BITS - 1);

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [4:0] {
        OP_LOAD,
        OP_TURN,
        OP_R_HI,
        OP_R_LO,
        OP_REQ,
        OP_ERR,
        OP_PROP,
        OP_INTEG,
        OP_ICLAMP,
        OP_SUM,
        OP_F_HI,
        OP_F_LO,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DACC_ADD,
        OP_DACC_CLAMP,
        OP_DRIVE,
        OP_DECAY,
        OP_OUT
    } op_t;

    // sequencing: fall through, wait for an input transfer, loop on counter,
    // wait for the output register then jump
    typedef enum logic [1:0] {
        JC_NEXT,
        JC_WAIT_START,
        JC_LOOP,
        JC_WAIT_OUT
    } jc_t;

    typedef struct packed {
        op_t  op;
        jc_t  jc;
        upc_t target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic start;
        logic out_write;
    } ctrl_t;

    // microprogram addresses
    localparam upc_t UA_IDLE       = 5'd0;
    localparam upc_t UA_TURN       = 5'd1;
    localparam upc_t UA_R_HI       = 5'd2;
    localparam upc_t UA_R_LO       = 5'd3;
    localparam upc_t UA_REQ        = 5'd4;
    localparam upc_t UA_ERR        = 5'd5;
    localparam upc_t UA_PROP       = 5'd6;
    localparam upc_t UA_INTEG      = 5'd7;
    localparam upc_t UA_ICLAMP     = 5'd8;
    localparam upc_t UA_SUM        = 5'd9;
    localparam upc_t UA_F_HI       = 5'd10;
    localparam upc_t UA_F_LO       = 5'd11;
    localparam upc_t UA_DIV_INIT   = 5'd12;
    localparam upc_t UA_DIV_STEP   = 5'd13;
    localparam upc_t UA_DACC_ADD   = 5'd14;
    localparam upc_t UA_DACC_CLAMP = 5'd15;
    localparam upc_t UA_DRIVE      = 5'd16;
    localparam upc_t UA_DECAY      = 5'd17;
    localparam upc_t UA_OUT        = 5'd18;

    typedef struct packed {
        logic        wheel_side;
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [13:0] max_rpm;
        logic [15:0] pwm_full_scale;
        logic [15:0] pwm_period;
        logic [15:0] half_track;
        logic [23:0] speed_to_rpm;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        wheel_side:     1'b0,
        prop_gain:      16'd256,
        integ_gain:     16'd26,
        max_rpm:        14'd6000,
        pwm_full_scale: 16'd1000,
        pwm_period:     16'd1000,
        half_track:     16'd128,
        speed_to_rpm:   24'd25600
    };

    // configuration register indexes
    localparam logic [2:0] CFG_WHEEL_SIDE     = 3'd0;
    localparam logic [2:0] CFG_PROP_GAIN      = 3'd1;
    localparam logic [2:0] CFG_INTEG_GAIN     = 3'd2;
    localparam logic [2:0] CFG_MAX_RPM        = 3'd3;
    localparam logic [2:0] CFG_PWM_FULL_SCALE = 3'd4;
    localparam logic [2:0] CFG_PWM_PERIOD     = 3'd5;
    localparam logic [2:0] CFG_HALF_TRACK     = 3'd6;
    localparam logic [2:0] CFG_SPEED_TO_RPM   = 3'd7;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // control store
    function automatic uword_t ucode_rom(input upc_t addr);
        uword_t uw;
        uw = '{op: OP_LOAD, jc: JC_WAIT_START, target: UA_IDLE};
        unique case (addr)
            UA_IDLE:       uw = '{op: OP_LOAD,       jc: JC_WAIT_START, target: UA_IDLE};
            UA_TURN:       uw = '{op: OP_TURN,       jc: JC_NEXT,       target: UA_IDLE};
            UA_R_HI:       uw = '{op: OP_R_HI,       jc: JC_NEXT,       target: UA_IDLE};
            UA_R_LO:       uw = '{op: OP_R_LO,       jc: JC_NEXT,       target: UA_IDLE};
            UA_REQ:        uw = '{op: OP_REQ,        jc: JC_NEXT,       target: UA_IDLE};
            UA_ERR:        uw = '{op: OP_ERR,        jc: JC_NEXT,       target: UA_IDLE};
            UA_PROP:       uw = '{op: OP_PROP,       jc: JC_NEXT,       target: UA_IDLE};
            UA_INTEG:      uw = '{op: OP_INTEG,      jc: JC_NEXT,       target: UA_IDLE};
            UA_ICLAMP:     uw = '{op: OP_ICLAMP,     jc: JC_NEXT,       target: UA_IDLE};
            UA_SUM:        uw = '{op: OP_SUM,        jc: JC_NEXT,       target: UA_IDLE};
            UA_F_HI:       uw = '{op: OP_F_HI,       jc: JC_NEXT,       target: UA_IDLE};
            UA_F_LO:       uw = '{op: OP_F_LO,       jc: JC_NEXT,       target: UA_IDLE};
            UA_DIV_INIT:   uw = '{op: OP_DIV_INIT,   jc: JC_NEXT,       target: UA_IDLE};
            UA_DIV_STEP:   uw = '{op: OP_DIV_STEP,   jc: JC_LOOP,       target: UA_IDLE};
            UA_DACC_ADD:   uw = '{op: OP_DACC_ADD,   jc: JC_NEXT,       target: UA_IDLE};
            UA_DACC_CLAMP: uw = '{op: OP_DACC_CLAMP, jc: JC_NEXT,       target: UA_IDLE};
            UA_DRIVE:      uw = '{op: OP_DRIVE,      jc: JC_NEXT,       target: UA_IDLE};
            UA_DECAY:      uw = '{op: OP_DECAY,      jc: JC_NEXT,       target: UA_IDLE};
            UA_OUT:        uw = '{op: OP_OUT,        jc: JC_WAIT_OUT,   target: UA_IDLE};
            default:       uw = '{op: OP_LOAD,       jc: JC_WAIT_START, target: UA_IDLE};
        endcase
        return uw;
    endfunction

endpackage

`default_nettype wire

// File: rtl/wspd_useq.sv
// Microsequencer: step counter, control store lookup, loop counter.
// Depends on wspd_pkg (control word layout and microprogram).
`default_nettype none

module wspd_useq
    import wspd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  out_busy,
    output logic       in_stall,
    output ctrl_t      ctrl
);

    upc_t             pc_reg;
    upc_t             pc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    uword_t           uw;
    logic             start;

    assign uw       = ucode_rom(pc_reg);
    assign in_stall = (uw.jc != JC_WAIT_START);
    assign start    = in_valid && !in_stall;

    always_comb
    begin
        pc_next  = pc_reg + 1'b1;
        cnt_next = DIV_LAST;
        unique case (uw.jc)
            JC_NEXT:
            begin
            end
            JC_WAIT_START:
            begin
                if (!start)
                begin
                    pc_next = pc_reg;
                end
            end
            JC_LOOP:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg != '0)
                begin
                    pc_next = pc_reg;
                end
            end
            JC_WAIT_OUT:
            begin
                pc_next = out_busy ? pc_reg : uw.target;
            end
            default:
            begin
                pc_next = UA_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= UA_IDLE;
            cnt_reg <= DIV_LAST;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign ctrl.op        = uw.op;
    assign ctrl.start     = start;
    assign ctrl.out_write = (uw.op == OP_OUT) && !out_busy;

    a_start_enters_program: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (pc_reg == UA_TURN))
        else $error("input transfer did not start the program");

    a_div_count_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == OP_DIV_INIT) |=> (cnt_reg == DIV_LAST))
        else $error("divide loop counter not preloaded");

    a_div_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.jc == JC_LOOP && cnt_reg == '0) |=> (pc_reg == UA_DACC_ADD))
        else $error("divide loop did not exit on last step");

endmodule

`default_nettype wire

// File: rtl/wspd_dpath.sv
// Datapath: shared 34x16 multiplier, accumulator, radix-2 divider, state
// registers and output register, all steered by the microcode op.
// Depends on wspd_pkg.
`default_nettype none

module wspd_dpath
    import wspd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_t              ctrl,
    input  wire cfg_t               cfg,
    input  wire logic signed [15:0] linear_speed,
    input  wire logic signed [15:0] angular_speed,
    input  wire logic signed [14:0] measured_rpm,
    input  wire logic               out_stall,
    output logic                    out_busy,
    output logic                    out_valid,
    output logic [15:0]             compare_value,
    output logic [1:0]              direction,
    output logic signed [16:0]      drive_level,
    output logic signed [14:0]      request_rpm
);

    localparam logic signed [ACC_W-1:0]   REQ_DB   = ACC_W'(DEADBAND_RPM * (2 ** 24));
    localparam logic signed [INTEG_W-1:0] INTEG_DB = INTEG_W'(DEADBAND_RPM * (2 ** 16));
    localparam logic signed [DACC_W-1:0]  DACC_ONE = DACC_W'(2 ** 16);

    // latched item
    logic signed [15:0]         lin_reg;
    logic signed [15:0]         ang_reg;
    logic signed [14:0]         meas_reg;
    // working registers
    logic signed [WHEEL_W-1:0]  wheel_reg,  wheel_next;
    logic signed [ACC_W-1:0]    acc_reg,    acc_next;
    logic signed [REQ_W-1:0]    req_reg,    req_next;
    logic signed [ERR_W-1:0]    err_reg,    err_next;
    logic signed [SUM_W-1:0]    sum_reg,    sum_next;
    logic [DIV_BITS-1:0]        num_reg,    num_next;
    logic [DEN_W-1:0]           rem_reg,    rem_next;
    logic                       neg_reg,    neg_next;
    logic signed [DRIVE_W-1:0]  drive_reg,  drive_next;
    // controller state
    logic signed [INTEG_W-1:0]  integ_reg,  integ_next;
    logic signed [DACC_W-1:0]   dacc_reg,   dacc_next;
    logic [15:0]                held_reg,   held_next;
    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [15:0]                compare_value_reg;
    logic [1:0]                 direction_reg, direction_next;
    logic signed [DRIVE_W-1:0]  drive_level_reg;
    logic signed [REQ_W-1:0]    request_rpm_reg;

    // shared multiplier
    logic signed [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;

    // derived terms
    logic signed [WHEEL_W-1:0]  lin_term;
    logic signed [WHEEL_W-1:0]  turn_term;
    logic signed [ACC_W-1:0]    r_max;
    logic signed [ACC_W-1:0]    r_quot;
    logic signed [REQ_W-1:0]    max_s;
    logic signed [ACC_W-1:0]    i_lim;
    logic signed [ACC_W-1:0]    d_lim;
    logic signed [ACC_W-1:0]    acc_mag;
    logic signed [ACC_W-1:0]    q_signed;
    logic signed [DACC_W-1:0]   d_quot;
    logic [DEN_W-1:0]           den;
    logic [DEN_W:0]             rem_sh;
    logic [DEN_W+1:0]           rem_diff;
    logic signed [DRIVE_W-1:0]  drive_mag;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.op)
            OP_TURN:
            begin
                mul_a = MUL_A_W'(ang_reg);
                mul_b = cfg.half_track;
            end
            OP_R_HI:
            begin
                mul_a = MUL_A_W'(wheel_reg);
                mul_b = MUL_B_W'(cfg.speed_to_rpm[23:12]);
            end
            OP_R_LO:
            begin
                mul_a = MUL_A_W'(wheel_reg);
                mul_b = MUL_B_W'(cfg.speed_to_rpm[11:0]);
            end
            OP_PROP:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = cfg.prop_gain;
            end
            OP_INTEG:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = cfg.integ_gain;
            end
            OP_F_HI:
            begin
                mul_a = MUL_A_W'(sum_reg >>> 17);
                mul_b = cfg.pwm_full_scale;
            end
            OP_F_LO:
            begin
                mul_a = $signed(MUL_A_W'(sum_reg[16:0]));
                mul_b = cfg.pwm_full_scale;
            end
            default:
            begin
            end
        endcase
        mul_p = mul_a * $signed({1'b0, mul_b});
    end

    assign lin_term  = WHEEL_W'(lin_reg) <<< 8;
    assign turn_term = $signed(mul_p[WHEEL_W-1:0]);
    assign r_max     = $signed(ACC_W'({cfg.max_rpm, 24'd0}));
    assign r_quot    = (acc_reg >>> 24)
                     + ACC_W'(acc_reg[ACC_W-1] && (acc_reg[23:0] != '0));
    assign max_s     = $signed({1'b0, cfg.max_rpm});
    assign i_lim     = $signed(ACC_W'({cfg.max_rpm, 16'd0}));
    assign d_lim     = $signed(ACC_W'({cfg.pwm_full_scale, 16'd0}));
    assign acc_mag   = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign q_signed  = neg_reg ? -$signed(ACC_W'(num_reg)) : $signed(ACC_W'(num_reg));
    assign d_quot    = (dacc_reg >>> 16)
                     + DACC_W'(dacc_reg[DACC_W-1] && (dacc_reg[15:0] != '0));
    // zero rpm limit divides by one
    assign den       = (cfg.max_rpm == '0) ? DEN_W'(1) : cfg.max_rpm;
    assign rem_sh    = {rem_reg, num_reg[DIV_BITS-1]};
    assign rem_diff  = {1'b0, rem_sh} - {2'b00, den};
    assign drive_mag = drive_reg[DRIVE_W-1] ? -drive_reg : drive_reg;

    always_comb
    begin
        wheel_next     = wheel_reg;
        acc_next       = acc_reg;
        req_next       = req_reg;
        err_next       = err_reg;
        sum_next       = sum_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        drive_next     = drive_reg;
        integ_next     = integ_reg;
        dacc_next      = dacc_reg;
        held_next      = held_reg;
        direction_next = DIR_STOP;
        case (ctrl.op)
            OP_TURN:
            begin
                wheel_next = cfg.wheel_side ? (lin_term + turn_term) : (lin_term - turn_term);
            end
            OP_R_HI, OP_F_HI:
            begin
                acc_next = ACC_W'(mul_p);
            end
            OP_R_LO:
            begin
                acc_next = (acc_reg <<< 12) + ACC_W'(mul_p);
            end
            OP_REQ:
            begin
                // deadband first, then clamp, then truncate toward zero
                if (acc_reg >= -REQ_DB && acc_reg <= REQ_DB)
                begin
                    req_next = '0;
                end
                else if (acc_reg > r_max)
                begin
                    req_next = max_s;
                end
                else if (acc_reg < -r_max)
                begin
                    req_next = -max_s;
                end
                else
                begin
                    req_next = $signed(r_quot[REQ_W-1:0]);
                end
            end
            OP_ERR:
            begin
                err_next = ERR_W'(req_reg) - ERR_W'(meas_reg);
            end
            OP_PROP:
            begin
                sum_next = SUM_W'(mul_p) <<< 8;
            end
            OP_INTEG:
            begin
                acc_next = ACC_W'(integ_reg) + (ACC_W'(mul_p) <<< 8);
            end
            OP_ICLAMP:
            begin
                if (acc_reg > i_lim)
                begin
                    integ_next = INTEG_W'(i_lim);
                end
                else if (acc_reg < -i_lim)
                begin
                    integ_next = INTEG_W'(-i_lim);
                end
                else
                begin
                    integ_next = INTEG_W'(acc_reg);
                end
            end
            OP_SUM:
            begin
                // small integrator is ignored
                if (integ_reg > INTEG_DB || integ_reg < -INTEG_DB)
                begin
                    sum_next = sum_reg + SUM_W'(integ_reg);
                end
            end
            OP_F_LO:
            begin
                acc_next = (acc_reg <<< 17) + ACC_W'(mul_p);
            end
            OP_DIV_INIT:
            begin
                neg_next = acc_reg[ACC_W-1];
                num_next = acc_mag[DIV_BITS-1:0];
                rem_next = '0;
            end
            OP_DIV_STEP:
            begin
                if (!rem_diff[DEN_W+1])
                begin
                    rem_next = rem_diff[DEN_W-1:0];
                    num_next = {num_reg[DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[DEN_W-1:0];
                    num_next = {num_reg[DIV_BITS-2:0], 1'b0};
                end
            end
            OP_DACC_ADD:
            begin
                acc_next = ACC_W'(dacc_reg) + q_signed;
            end
            OP_DACC_CLAMP:
            begin
                if (acc_reg > d_lim)
                begin
                    dacc_next = DACC_W'(d_lim);
                end
                else if (acc_reg < -d_lim)
                begin
                    dacc_next = DACC_W'(-d_lim);
                end
                else
                begin
                    dacc_next = DACC_W'(acc_reg);
                end
            end
            OP_DRIVE:
            begin
                drive_next = $signed(d_quot[DRIVE_W-1:0]);
            end
            OP_DECAY:
            begin
                // zero request: bleed one unit toward zero
                if (req_reg == '0)
                begin
                    if (drive_reg > 0)
                    begin
                        dacc_next = dacc_reg - DACC_ONE;
                    end
                    else if (drive_reg < 0)
                    begin
                        dacc_next = dacc_reg + DACC_ONE;
                    end
                end
            end
            OP_OUT:
            begin
                if (drive_reg != '0)
                begin
                    held_next = cfg.pwm_period - drive_mag[15:0];
                end
                if (drive_reg > 0)
                begin
                    direction_next = DIR_FWD;
                end
                else if (drive_reg < 0)
                begin
                    direction_next = DIR_REV;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_busy = out_valid_reg && out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.out_write)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            dacc_reg      <= '0;
            held_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            dacc_reg      <= dacc_next;
            if (ctrl.out_write)
            begin
                held_reg <= held_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            lin_reg  <= linear_speed;
            ang_reg  <= angular_speed;
            meas_reg <= measured_rpm;
        end
        wheel_reg <= wheel_next;
        acc_reg   <= acc_next;
        req_reg   <= req_next;
        err_reg   <= err_next;
        sum_reg   <= sum_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        drive_reg <= drive_next;
        if (ctrl.out_write)
        begin
            compare_value_reg <= held_next;
            direction_reg     <= direction_next;
            drive_level_reg   <= drive_reg;
            request_rpm_reg   <= req_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign compare_value = compare_value_reg;
    assign direction     = direction_reg;
    assign drive_level   = drive_level_reg;
    assign request_rpm   = request_rpm_reg;

    a_no_overwrite_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_write |-> !(out_valid_reg && out_stall))
        else $error("result written over a stalled result");

    a_dir_matches_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((direction_reg == DIR_STOP) == (drive_level_reg == '0)))
        else $error("direction disagrees with drive level");

    a_held_on_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.out_write && drive_reg == '0) |=> (held_reg == $past(held_reg)))
        else $error("compare value changed on zero drive");

endmodule

`default_nettype wire

// File: rtl/wheel_speed_pi_drive_core.sv
// Top level of the wheel speed PI drive: configuration registers plus
// the microsequencer and datapath. Depends on wspd_pkg, wspd_useq, wspd_dpath.
// Usage
//   Input channel (in_valid / in_stall): one control tick per transfer,
//   carrying linear_speed, angular_speed and measured_rpm. in_stall is low
//   only while the sequencer sits at its idle step.
//   Output channel (out_valid / out_stall): exactly one result per tick,
//   held in an output register; a stalled result keeps its value, and the
//   next tick is accepted while it waits. The program only stalls at its
//   last step if the previous result has still not been taken.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
//   registers only between ticks.
// Program
//   Each tick runs from the idle step through single microcode steps around
//   the shared 34x16 multiplier and the radix-2 divide loop for
//   (P+I)*full_scale/max_rpm; the result is written at the last step, and
//   the next input is taken once the program is back at its idle step.
// Reset
//   Async, active low: configuration returns to defaults, integrator, drive
//   accumulator and held compare value clear, no result pending.
`default_nettype none

module wheel_speed_pi_drive_core
    import wspd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // tick input
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] linear_speed,
    input  wire logic signed [15:0] angular_speed,
    input  wire logic signed [14:0] measured_rpm,
    // result output
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [15:0]             compare_value,
    output logic [1:0]              direction,
    output logic signed [16:0]      drive_level,
    output logic signed [14:0]      request_rpm,
    // register writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [23:0]        cfg_data
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    ctrl_t ctrl;
    logic  out_busy;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WHEEL_SIDE:     cfg_next.wheel_side     = cfg_data[0];
                CFG_PROP_GAIN:      cfg_next.prop_gain      = cfg_data[15:0];
                CFG_INTEG_GAIN:     cfg_next.integ_gain     = cfg_data[15:0];
                CFG_MAX_RPM:        cfg_next.max_rpm        = cfg_data[13:0];
                CFG_PWM_FULL_SCALE: cfg_next.pwm_full_scale = cfg_data[15:0];
                CFG_PWM_PERIOD:     cfg_next.pwm_period     = cfg_data[15:0];
                CFG_HALF_TRACK:     cfg_next.half_track     = cfg_data[15:0];
                CFG_SPEED_TO_RPM:   cfg_next.speed_to_rpm   = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // step counter and control store
    wspd_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    // arithmetic, controller state and result register
    wspd_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .cfg           (cfg_reg),
        .linear_speed  (linear_speed),
        .angular_speed (angular_speed),
        .measured_rpm  (measured_rpm),
        .out_stall     (out_stall),
        .out_busy      (out_busy),
        .out_valid     (out_valid),
        .compare_value (compare_value),
        .direction     (direction),
        .drive_level   (drive_level),
        .request_rpm   (request_rpm)
    );

endmodule

`default_nettype wire

// File: tb/wheel_speed_pi_drive_core_tb.sv
// Self-checking bench for wheel_speed_pi_drive_core: a tracker class predicts every tick's
// result from its own copy of the registers and PI state and compares the output transfers.
// Depends on wspd_pkg (cfg_t, register indexes, direction codes) and the core RTL.

module wheel_speed_pi_drive_core_tb;
    import wspd_pkg::*;

    localparam int TICKS_PER_PHASE = 200;
    localparam int PHASES          = 10;
    localparam int QUIET_PHASE     = 5;          // no idling or stalls on either side
    localparam int TAIL_CYCLES     = 100;        // run-out after the final settle
    localparam int LIMIT_CYCLES    = 2_000_000;
    localparam longint Q16         = 64'sd65536;

    // one expected output transfer
    typedef struct {
        logic [15:0]        cmp;
        logic [1:0]         dir;
        logic signed [16:0] drv;
        logic signed [14:0] req;
    } wheel_result_t;

    // Tracks the block: register copy, integrator, drive accumulator, held compare value,
    // and the results still due on the output channel.
    class pi_drive_tracker;
        cfg_t          regs;
        longint        integ_acc;
        longint        drive_acc;
        logic [15:0]   held_cmp;
        wheel_result_t results_due[$];
        int            errors;
        int            checked;

        function new();
            regs      = CFG_RESET;
            integ_acc = 0;
            drive_acc = 0;
            held_cmp  = '0;
            errors    = 0;
            checked   = 0;
        endfunction

        function longint clamp_sym(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] data);
            case (idx)
                CFG_WHEEL_SIDE:     regs.wheel_side     = data[0];
                CFG_PROP_GAIN:      regs.prop_gain      = data[15:0];
                CFG_INTEG_GAIN:     regs.integ_gain     = data[15:0];
                CFG_MAX_RPM:        regs.max_rpm        = data[13:0];
                CFG_PWM_FULL_SCALE: regs.pwm_full_scale = data[15:0];
                CFG_PWM_PERIOD:     regs.pwm_period     = data[15:0];
                CFG_HALF_TRACK:     regs.half_track     = data[15:0];
                CFG_SPEED_TO_RPM:   regs.speed_to_rpm   = data[23:0];
                default: ;
            endcase
        endfunction

        // One control tick: request, PI law, drive accumulator, compare value.
        function void note_tick(logic signed [15:0] lin, logic signed [15:0] ang,
                                logic signed [14:0] meas);
            longint        one24, rpm_lim, divisor, full, turn, wheel, rate;
            longint        req, err, prop, total, drv;
            wheel_result_t res;
            one24   = 64'sd1 <<< 24;
            rpm_lim = longint'(regs.max_rpm);
            divisor = (regs.max_rpm != 0) ? rpm_lim : 64'sd1;
            full    = longint'(regs.pwm_full_scale);

            turn  = longint'(ang) * longint'(regs.half_track);
            wheel = longint'(lin) * 256 + (regs.wheel_side ? turn : -turn);
            rate  = wheel * longint'(regs.speed_to_rpm);

            // deadband first, then the rpm clamp
            if (rate >= -DEADBAND_RPM * one24 && rate <= DEADBAND_RPM * one24)
                req = 0;
            else if (rate > rpm_lim * one24)
                req = rpm_lim;
            else if (rate < -rpm_lim * one24)
                req = -rpm_lim;
            else
                req = rate / one24;

            err       = req - longint'(meas);
            prop      = longint'(regs.prop_gain) * err * 256;
            integ_acc = clamp_sym(integ_acc + longint'(regs.integ_gain) * err * 256,
                                  rpm_lim * Q16);
            if (integ_acc <= DEADBAND_RPM * Q16 && integ_acc >= -DEADBAND_RPM * Q16)
                total = prop;
            else
                total = prop + integ_acc;

            drive_acc = clamp_sym(drive_acc + (total * full) / divisor, full * Q16);
            drv       = drive_acc / Q16;

            // zero request: bleed the accumulator one step toward zero
            if (req == 0) begin
                if (drv > 0)
                    drive_acc -= Q16;
                if (drv < 0)
                    drive_acc += Q16;
            end

            if (drv < 0) begin
                held_cmp = 16'(longint'(regs.pwm_period) + drv);
                res.dir  = DIR_REV;
            end else if (drv > 0) begin
                held_cmp = 16'(longint'(regs.pwm_period) - drv);
                res.dir  = DIR_FWD;
            end else begin
                res.dir  = DIR_STOP;
            end
            res.cmp = held_cmp;
            res.drv = 17'(drv);
            res.req = 15'(req);
            results_due.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(logic [15:0] cmp, logic [1:0] dir, logic signed [16:0] drv,
                          logic signed [14:0] req);
            wheel_result_t res;
            if (results_due.size() == 0) begin
                report($sformatf("unexpected result cmp=%0d dir=%0d drv=%0d req=%0d",
                                 cmp, dir, drv, req));
                return;
            end
            res = results_due.pop_front();
            checked++;
            if (cmp !== res.cmp)
                report($sformatf("result %0d compare_value %0d, want %0d",
                                 checked, cmp, res.cmp));
            if (dir !== res.dir)
                report($sformatf("result %0d direction %0d, want %0d", checked, dir, res.dir));
            if (drv !== res.drv)
                report($sformatf("result %0d drive_level %0d, want %0d", checked, drv, res.drv));
            if (req !== res.req)
                report($sformatf("result %0d request_rpm %0d, want %0d",
                                 checked, req, res.req));
        endtask

        task flush();
            while (results_due.size() != 0) begin
                void'(results_due.pop_front());
                report("result never arrived");
            end
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic signed [15:0] linear_speed  = '0;
    logic signed [15:0] angular_speed = '0;
    logic signed [14:0] measured_rpm  = '0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic [15:0]        compare_value;
    logic [1:0]         direction;
    logic signed [16:0] drive_level;
    logic signed [14:0] request_rpm;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index     = '0;
    logic [23:0]        cfg_data      = '0;

    pi_drive_tracker tracker;
    bit              quiet      = 1'b0;   // set during the stretch with no idling
    int              ticks_sent = 0;
    int              cfg_writes = 0;
    int              settings   = 0;
    int unsigned     cycles     = 0;
    int              stall_hold = 0;

    // generator state for held speed commands
    int                 burst_left = 0;
    logic signed [15:0] hold_lin   = '0;
    logic signed [15:0] hold_ang   = '0;
    int                 hold_meas  = 0;

    wheel_speed_pi_drive_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .linear_speed  (linear_speed),
        .angular_speed (angular_speed),
        .measured_rpm  (measured_rpm),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .compare_value (compare_value),
        .direction     (direction),
        .drive_level   (drive_level),
        .request_rpm   (request_rpm),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit: well past the slowest legal run (long gaps and long stalls on every tick).
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     tracker.results_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Output side back-pressure: ~21% random stall cycles, plus a rare long hold
    // that can outlast a whole tick so the program may have to wait at its last step.
    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
            out_stall  <= 1'b1;
        end
        else if (!quiet && $urandom_range(1999) == 0)
        begin
            stall_hold <= $urandom_range(150, 50);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= !quiet && ($urandom_range(99) < 21);
        end
    end

    // Output monitor: a transfer happens when valid is high and stall low at the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(compare_value, direction, drive_level, request_rpm);
    end

    function automatic int rand_span(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // One input transfer. Called right after clk rises; may idle first.
    task automatic send_tick(input logic signed [15:0] lin, input logic signed [15:0] ang,
                             input logic signed [14:0] meas);
        int gap;
        gap = 0;
        if (!quiet)
        begin
            if ($urandom_range(99) < 3)
                gap = $urandom_range(80, 20);   // long gap, sometimes past the return to the idle step
            else
                while ($urandom_range(99) < 21)
                    gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        linear_speed  <= lin;
        angular_speed <= ang;
        measured_rpm  <= meas;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_tick(lin, ang, meas);
        ticks_sent++;
    endtask

    // Drop valid and wait until every result is in and the sequencer is idle.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.results_due.size() != 0 || in_stall)
            @(posedge clk);
    endtask

    // Write all eight registers back to back; sometimes with junk above each field narrower than 24 bits.
    task automatic program_regs(input cfg_t c);
        logic [2:0]  idx_list[8];
        logic [23:0] vals[8];
        int          field_w[8];
        logic [23:0] data;
        idx_list = '{CFG_WHEEL_SIDE, CFG_PROP_GAIN, CFG_INTEG_GAIN, CFG_MAX_RPM,
                     CFG_PWM_FULL_SCALE, CFG_PWM_PERIOD, CFG_HALF_TRACK, CFG_SPEED_TO_RPM};
        vals     = '{24'(c.wheel_side), 24'(c.prop_gain), 24'(c.integ_gain),
                     24'(c.max_rpm), 24'(c.pwm_full_scale), 24'(c.pwm_period),
                     24'(c.half_track), 24'(c.speed_to_rpm)};
        field_w  = '{1, 16, 16, 14, 16, 16, 16, 24};
        for (int i = 0; i < 8; i++)
        begin
            data = vals[i];
            if ($urandom_range(1) == 1)
                data = data | (24'($urandom) & ~((24'd1 << field_w[i]) - 24'd1));
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            tracker.set_reg(idx_list[i], data);
            cfg_writes++;
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Random register set: most fields sometimes at an extreme, else a working or random value.
    function automatic cfg_t rand_regs();
        cfg_t c;
        c.wheel_side     = 1'($urandom);
        c.prop_gain      = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(4096));
        c.integ_gain     = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1024));
        c.max_rpm        = ($urandom_range(9) == 0) ? 14'($urandom_range(50))
                                                    : 14'($urandom_range(16383, 51));
        c.pwm_full_scale = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom);
        c.pwm_period     = 16'($urandom);
        c.half_track     = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1024));
        c.speed_to_rpm   = ($urandom_range(9) == 0) ? 24'($urandom)
                                                    : 24'($urandom_range(1 << 17));
        return c;
    endfunction

    // Next random tick: mostly held speed commands with a noisy measurement so the
    // accumulator can build and saturate, some near-stop ticks for the deadband and
    // decay, and some raw noise across every bit.
    task automatic next_tick(output logic signed [15:0] lin, output logic signed [15:0] ang,
                             output logic signed [14:0] meas);
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
        begin
            lin  = 16'($urandom);
            ang  = 16'($urandom);
            meas = 15'($urandom);
        end
        else if (roll < 30)
        begin
            lin  = 16'(rand_span(-200, 200));
            ang  = 16'(rand_span(-300, 300));
            meas = 15'(rand_span(-120, 120));
        end
        else
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(40, 1);
                hold_lin   = ($urandom_range(3) == 0) ? 16'($urandom)
                                                      : 16'(rand_span(-3000, 3000));
                hold_ang   = ($urandom_range(2) == 0) ? 16'sd0
                                                      : 16'(rand_span(-4000, 4000));
                hold_meas  = ($urandom_range(3) == 0) ? rand_span(-16384, 16383)
                                                      : rand_span(-3000, 3000);
            end
            burst_left--;
            lin  = hold_lin;
            ang  = hold_ang;
            meas = 15'(hold_meas + rand_span(-60, 60));
        end
    endtask

    initial
    begin
        cfg_t               plan;
        logic signed [15:0] lin;
        logic signed [15:0] ang;
        logic signed [14:0] meas;

        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ticks on reset register values ----
        send_tick(16'sd0, 16'sd0, 15'sd0);
        send_tick(16'sd32767, 16'sd0, 15'sd0);        // request clamps at max_rpm
        send_tick(16'sd32767, 16'sd0, 15'sd0);        // drive saturates at full scale
        send_tick(16'sd0, 16'sd0, 15'sd0);            // zero request, decay toward zero
        send_tick(-16'sd32768, 16'sd0, 15'sd0);
        send_tick(16'sd0, 16'sd32767, 15'sd0);        // angular term subtracted
        send_tick(16'sd0, -16'sd32768, 15'sd0);
        send_tick(16'sd128, 16'sd0, 15'sd0);          // exactly on the deadband edge
        send_tick(16'sd129, 16'sd0, 15'sd0);          // just outside it
        send_tick(-16'sd128, 16'sd0, 15'sd0);
        send_tick(-16'sd129, 16'sd0, 15'sd0);
        send_tick(16'sd0, 16'sd0, 15'sd16383);
        send_tick(16'sd0, 16'sd0, -15'sd16384);
        send_tick(16'sd0, 16'sd0, 15'sd0);

        // drive magnitude beyond a short period: compare value wraps
        settle();
        plan = tracker.regs;
        plan.pwm_period = 16'd100;
        program_regs(plan);
        send_tick(16'sd32767, 16'sd0, -15'sd16384);
        send_tick(16'sd32767, 16'sd0, -15'sd16384);
        send_tick(16'sd32767, 16'sd0, -15'sd16384);
        send_tick(-16'sd32768, 16'sd0, 15'sd16383);
        send_tick(-16'sd32768, 16'sd0, 15'sd16383);

        // zero rpm limit: divisor falls back to one, clamps stay at zero
        settle();
        plan.max_rpm = 14'd0;
        program_regs(plan);
        send_tick(16'sd1000, 16'sd0, 15'sd0);
        send_tick(-16'sd1000, 16'sd0, 15'sd500);

        // rpm limit under the deadband: request is zero or the limit
        settle();
        plan.max_rpm    = 14'd30;
        plan.wheel_side = 1'b1;
        program_regs(plan);
        send_tick(16'sd129, 16'sd0, 15'sd0);
        send_tick(16'sd0, 16'sd0, 15'sd0);

        // ---- random phases, one register set each ----
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0: plan = CFG_RESET;
                1: plan = '{wheel_side: 1'b1, prop_gain: 16'hFFFF, integ_gain: 16'hFFFF,
                            max_rpm: 14'h3FFF, pwm_full_scale: 16'hFFFF,
                            pwm_period: 16'hFFFF, half_track: 16'hFFFF,
                            speed_to_rpm: 24'hFFFFFF};
                2: plan = '0;
                3: plan = '{wheel_side: 1'b0, prop_gain: 16'd512, integ_gain: 16'd64,
                            max_rpm: 14'd30, pwm_full_scale: 16'd255,
                            pwm_period: 16'd200, half_track: 16'd128,
                            speed_to_rpm: 24'd25600};
                default: plan = rand_regs();
            endcase
            program_regs(plan);
            quiet = (ph == QUIET_PHASE);
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                next_tick(lin, ang, meas);
                send_tick(lin, ang, meas);
            end
            quiet = 1'b0;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        tracker.flush();

        $display("Covered %0d ticks under %0d register sets (%0d register writes).",
                 ticks_sent, settings, cfg_writes);
        $display("Checked %0d results, %0d mismatches.", tracker.checked, tracker.errors);
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: wheel_speed_pi_drive_core.f
rtl/wspd_pkg.sv
rtl/wspd_useq.sv
rtl/wspd_dpath.sv
rtl/wheel_speed_pi_drive_core.sv
tb/wheel_speed_pi_drive_core_tb.sv
